FILE: rtl/core/ofe_pkg.sv
// ----------------------------------------------------------------------------
// ofe_pkg: shared constants and helpers for the occlusion fade envelope
// Widths of the time, timer, alpha and configuration fields, fade phase
// codes, register indexes and the timer saturation function.
// ----------------------------------------------------------------------------
package ofe_pkg;

  // Time values are unsigned Q16 seconds
  localparam int TIME_WIDTH      = 24;
  localparam int ALPHA_FRAC_BITS = 16;
  localparam int STEP_W          = 20;

  // Timers are signed, two bits wider than a time value
  localparam int TMR_W = TIME_WIDTH + 2;
  // Subtractor width: one guard bit above the timer width
  localparam int ALU_W = TMR_W + 1;

  // Alpha covers 0 .. 2^ALPHA_FRAC_BITS inclusive
  localparam int ALPHA_W = ALPHA_FRAC_BITS + 1;
  // Divider takes one quotient bit per step
  localparam int DIV_STEPS = ALPHA_FRAC_BITS + 1;
  localparam int CNT_W     = $clog2(DIV_STEPS + 1);

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = TIME_WIDTH;

  localparam logic [CFG_IDX_W-1:0] REG_ENABLE        = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FADE_DURATION = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_PERIOD = 2'd2;

  localparam logic [TIME_WIDTH-1:0] FADE_DURATION_RST = TIME_WIDTH'(65536);
  localparam logic [TIME_WIDTH-1:0] SAMPLE_PERIOD_RST = TIME_WIDTH'(39322);

  // Fade phases
  localparam logic [1:0] PH_OFF = 2'd0;
  localparam logic [1:0] PH_IN  = 2'd1;
  localparam logic [1:0] PH_ON  = 2'd2;
  localparam logic [1:0] PH_OUT = 2'd3;

  localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(1) << ALPHA_FRAC_BITS;

  // Clamp a subtractor result to the signed timer range
  function automatic logic [TMR_W-1:0] sat_time(input logic [ALU_W-1:0] v);
    logic [TMR_W-1:0] r;
    if (v[ALU_W-1] != v[ALU_W-2]) begin
      r = v[ALU_W-1] ? {1'b1, {(TMR_W-1){1'b0}}} : {1'b0, {(TMR_W-1){1'b1}}};
    end else begin
      r = v[TMR_W-1:0];
    end
    return r;
  endfunction

endpackage

FILE: rtl/core/ofe_channels.sv
// ----------------------------------------------------------------------------
// ofe_channels: valid/ready channels of the occlusion fade envelope
// Tick input channel, result output channel and register write channel.
// ----------------------------------------------------------------------------
interface ofe_tick_if;
  import ofe_pkg::*;

  logic              valid;
  logic              ready;
  logic [STEP_W-1:0] time_step;
  logic              line_clear;
  logic              world_present;

  modport source (output valid, time_step, line_clear, world_present, input ready);
  modport sink   (input valid, time_step, line_clear, world_present, output ready);
endinterface

interface ofe_result_if;
  import ofe_pkg::*;

  logic               valid;
  logic               ready;
  logic [1:0]         fade_state;
  logic [ALPHA_W-1:0] alpha;
  logic               sampled_now;
  logic               visible;

  modport source (output valid, fade_state, alpha, sampled_now, visible, input ready);
  modport sink   (input valid, fade_state, alpha, sampled_now, visible, output ready);
endinterface

interface ofe_cfg_if;
  import ofe_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/core/occlusion_fade_envelope.sv
// ----------------------------------------------------------------------------
// occlusion_fade_envelope: fade envelope for an occludable light
// Visibility sampling timer, four-phase fade machine and a bit-serial
// alpha divider, all sharing one subtractor under a small sequencer.
// ----------------------------------------------------------------------------
// Sequence: a tick accepted while disabled goes straight to S_DONE; enabled,
//   it passes S_SAMPLE, S_FADE, then S_CLAMP and S_DIV while fading, then S_DONE.
// Flow: tick ready only while idle; S_DONE holds until the result register is
//   free. The result register lets the next tick enter while a result waits.
// Reset (rst, synchronous): idle, phase off, timers 0, latch 0, enable 0,
//   fade_duration 1.0 s, sample_period 0.6 s, no result pending.
// ----------------------------------------------------------------------------
module occlusion_fade_envelope (
  input  logic          clk,
  input  logic          rst,
  ofe_tick_if.sink      tick,
  ofe_result_if.source  result,
  ofe_cfg_if.sink       cfg
);
  import ofe_pkg::*;

  // Sequencer states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SAMPLE = 3'd1;
  localparam logic [2:0] S_FADE   = 3'd2;
  localparam logic [2:0] S_CLAMP  = 3'd3;
  localparam logic [2:0] S_DIV    = 3'd4;
  localparam logic [2:0] S_DONE   = 3'd5;

  logic [2:0] state;

  // Configuration registers
  logic                  enable;
  logic [TIME_WIDTH-1:0] fade_duration;
  logic [TIME_WIDTH-1:0] sample_period;

  // Block state
  logic [1:0]       phase;
  logic [TMR_W-1:0] fade_timer;
  logic [TMR_W-1:0] sample_timer;
  logic             visible_latch;
  logic             sampled;

  // Captured tick
  logic [STEP_W-1:0] step;
  logic              clear_in;
  logic              world_in;

  // Divider
  logic [TIME_WIDTH-1:0] rem;
  logic [ALPHA_W-1:0]    quo;
  logic [CNT_W-1:0]      cnt;

  // Shared subtractor
  logic [ALU_W-1:0] alu_a;
  logic [ALU_W-1:0] alu_b;
  logic [ALU_W-1:0] alu_d;
  logic [TMR_W-1:0] alu_sat;

  logic [TIME_WIDTH-1:0] flen;
  logic [TIME_WIDTH:0]   cand;
  logic                  mirror;
  logic                  div_ge;
  logic [1:0]            phase_next;
  logic [TMR_W-1:0]      fade_timer_next;
  logic [ALPHA_W-1:0]    alpha_next;
  logic                  out_free;

  // A zero fade length counts as one LSB
  assign flen = (fade_duration == '0) ? TIME_WIDTH'(1) : fade_duration;

  // A reversal mirrors the fade timer against the fade length
  assign mirror = (visible_latch && phase == PH_OUT) || (!visible_latch && phase == PH_IN);

  // Divider candidate: first step compares the remainder as is
  assign cand = (cnt == '0) ? {1'b0, rem} : {rem, 1'b0};

  // Operand selection for the subtractor
  always_comb begin
    alu_a = '0;
    alu_b = '0;
    case (state)
      S_SAMPLE: begin
        alu_a = {sample_timer[TMR_W-1], sample_timer};
        alu_b = ALU_W'(step);
      end
      S_FADE: begin
        if (mirror) begin
          alu_a = ALU_W'(flen);
          alu_b = {fade_timer[TMR_W-1], fade_timer};
        end else begin
          alu_a = {fade_timer[TMR_W-1], fade_timer};
          alu_b = ALU_W'(step);
        end
      end
      S_CLAMP: begin
        alu_a = ALU_W'(flen);
        alu_b = {fade_timer[TMR_W-1], fade_timer};
      end
      S_DIV: begin
        alu_a = ALU_W'(cand);
        alu_b = ALU_W'(flen);
      end
      default: begin
        alu_a = '0;
        alu_b = '0;
      end
    endcase
  end

  assign alu_d   = alu_a - alu_b;
  assign alu_sat = sat_time(alu_d);
  assign div_ge  = !alu_d[ALU_W-1];

  // Fade machine transition
  always_comb begin
    phase_next      = phase;
    fade_timer_next = fade_timer;
    if (visible_latch) begin
      case (phase)
        PH_OFF: begin
          phase_next      = PH_IN;
          fade_timer_next = TMR_W'(flen);
        end
        PH_IN: begin
          fade_timer_next = alu_sat;
          if (alu_sat[TMR_W-1]) phase_next = PH_ON;
        end
        PH_OUT: begin
          phase_next      = PH_IN;
          fade_timer_next = alu_sat;
        end
        default: begin
          phase_next = phase;
        end
      endcase
    end else begin
      case (phase)
        PH_IN: begin
          phase_next      = PH_OUT;
          fade_timer_next = alu_sat;
        end
        PH_OUT: begin
          fade_timer_next = alu_sat;
          if (alu_sat[TMR_W-1]) phase_next = PH_OFF;
        end
        PH_ON: begin
          phase_next      = PH_OUT;
          fade_timer_next = TMR_W'(flen);
        end
        default: begin
          phase_next = phase;
        end
      endcase
    end
  end

  // Alpha from phase and quotient
  always_comb begin
    case (phase)
      PH_ON:   alpha_next = ALPHA_ONE;
      PH_IN:   alpha_next = ALPHA_ONE - quo;
      PH_OUT:  alpha_next = quo;
      default: alpha_next = '0;
    endcase
  end

  assign out_free   = !result.valid || result.ready;
  assign tick.ready = (state == S_IDLE);
  assign cfg.ready  = 1'b1;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      enable        <= 1'b0;
      fade_duration <= FADE_DURATION_RST;
      sample_period <= SAMPLE_PERIOD_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_ENABLE:        enable        <= cfg.data[0];
        REG_FADE_DURATION: fade_duration <= cfg.data;
        REG_SAMPLE_PERIOD: sample_period <= cfg.data;
        default: begin
        end
      endcase
    end
  end

  // Sequencer and block state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      phase         <= PH_OFF;
      fade_timer    <= '0;
      sample_timer  <= '0;
      visible_latch <= 1'b0;
      sampled       <= 1'b0;
      result.valid  <= 1'b0;
    end else begin
      // S_DONE reloads the result register itself when it is freed
      if (result.valid && result.ready && state != S_DONE) result.valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (tick.valid) begin
            step     <= tick.time_step;
            clear_in <= tick.line_clear;
            world_in <= tick.world_present;
            sampled  <= 1'b0;
            if (enable) begin
              state <= S_SAMPLE;
            end else begin
              phase <= PH_OFF;
              state <= S_DONE;
            end
          end
        end
        S_SAMPLE: begin
          if (alu_sat[TMR_W-1]) begin
            sample_timer  <= TMR_W'(sample_period);
            visible_latch <= world_in ? clear_in : 1'b1;
            sampled       <= 1'b1;
          end else begin
            sample_timer <= alu_sat;
          end
          state <= S_FADE;
        end
        S_FADE: begin
          phase      <= phase_next;
          fade_timer <= fade_timer_next;
          if (phase_next == PH_IN || phase_next == PH_OUT) state <= S_CLAMP;
          else state <= S_DONE;
        end
        S_CLAMP: begin
          // t = fade timer clamped to 0 .. flen
          if (fade_timer[TMR_W-1]) rem <= '0;
          else if (alu_d[ALU_W-1]) rem <= flen;
          else rem <= fade_timer[TIME_WIDTH-1:0];
          quo   <= '0;
          cnt   <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          // One quotient bit per cycle, restoring
          rem <= div_ge ? alu_d[TIME_WIDTH-1:0] : cand[TIME_WIDTH-1:0];
          quo <= {quo[ALPHA_W-2:0], div_ge};
          cnt <= cnt + CNT_W'(1);
          if (cnt == CNT_W'(DIV_STEPS - 1)) state <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            result.valid       <= 1'b1;
            result.fade_state  <= phase;
            result.alpha       <= alpha_next;
            result.sampled_now <= sampled;
            result.visible     <= visible_latch;
            state              <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
